// File: rtl/core/rdc_pkg.sv
`default_nettype none

package rdc_pkg;

  // Field widths
  localparam int VALUE_BITS = 31;
  localparam int BASE_BITS  = 6;
  localparam int DIGIT_BITS = 6;
  localparam int CHAR_BITS  = 7;

  // Base limits and character mapping
  localparam logic [BASE_BITS-1:0]  BASE_MIN      = 6'd2;
  localparam logic [BASE_BITS-1:0]  BASE_MAX      = 6'd36;
  localparam logic [DIGIT_BITS-1:0] DEC_LIMIT     = 6'd9;
  localparam logic [CHAR_BITS-1:0]  LETTER_OFFSET = 7'd55;
  localparam logic [CHAR_BITS-1:0]  ZERO_CHAR     = 7'd48;
  localparam logic [CHAR_BITS-1:0]  BAD_CHAR      = 7'd0;

  // One classified item between front and back
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [BASE_BITS-1:0]  base;
    logic                  bad;
  } item_t;

  // Digit value to ASCII: 0-9 -> '0'-'9', 10-35 -> 'A'-'Z'
  function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] dw;
    dw = {1'b0, d};
    if (d > DEC_LIMIT) begin
      return dw + LETTER_OFFSET;
    end
    return dw + ZERO_CHAR;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rdc_front.sv
`default_nettype none

module rdc_front #(
  parameter int VW = 31
) (
  input  wire logic                                 in_valid,
  input  wire logic [rdc_pkg::VALUE_BITS-1:0]       in_value,
  input  wire logic [rdc_pkg::BASE_BITS-1:0]        in_target_base,
  output logic                                      in_ready,
  output logic                                      push_valid,
  output rdc_pkg::item_t                            push_item,
  input  wire logic                                 push_ready
);

  // Mask for the bits of value that take part in the conversion
  localparam logic [rdc_pkg::VALUE_BITS-1:0] VMASK =
    (VW >= rdc_pkg::VALUE_BITS) ? '1 :
    rdc_pkg::VALUE_BITS'((64'd1 << VW) - 64'd1);

  // Transfer straight into the queue
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  // Classify base and trim the value
  always_comb begin
    push_item.value = in_value & VMASK;
    push_item.base  = in_target_base;
    push_item.bad   = (in_target_base < rdc_pkg::BASE_MIN) ||
                      (in_target_base > rdc_pkg::BASE_MAX);
  end

endmodule

`default_nettype wire

// File: rtl/core/rdc_queue.sv
`default_nettype none

module rdc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  input  wire rdc_pkg::item_t  push_item,
  output logic                 push_ready,
  output logic                 pop_valid,
  output rdc_pkg::item_t       pop_item,
  input  wire logic            pop_ready
);

  // Two-entry queue
  rdc_pkg::item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rdc_div.sv
`default_nettype none

module rdc_div #(
  parameter int VW = 31
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [VW-1:0]                    dividend,
  input  wire logic [rdc_pkg::BASE_BITS-1:0]    divisor,
  output logic                                  done,
  output logic [VW-1:0]                         quotient,
  output logic [rdc_pkg::DIGIT_BITS-1:0]        remainder
);

  localparam int CNTW = $clog2(VW);

  // Restoring divider, one quotient bit per cycle
  logic [VW-1:0]                      acc_r, acc_nxt;
  logic [rdc_pkg::DIGIT_BITS-1:0]     rem_r, rem_nxt;
  logic [rdc_pkg::BASE_BITS-1:0]      div_r, div_nxt;
  logic [CNTW-1:0]                    cnt_r, cnt_nxt;
  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [rdc_pkg::DIGIT_BITS:0]       trial;
  logic [rdc_pkg::DIGIT_BITS:0]       diff;
  logic                               fits;

  assign trial = {rem_r, acc_r[VW-1]};
  assign diff  = trial - {1'b0, div_r};
  assign fits  = (trial >= {1'b0, div_r});

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = CNTW'(VW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[rdc_pkg::DIGIT_BITS-1:0] : trial[rdc_pkg::DIGIT_BITS-1:0];
      acc_nxt = {acc_r[VW-2:0], fits};
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done      = done_r;
  assign quotient  = acc_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// File: rtl/core/rdc_back.sv
`default_nettype none

module rdc_back #(
  parameter int VW = 31
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  input  wire rdc_pkg::item_t                   q_item,
  output logic                                  q_ready,
  output logic                                  out_valid,
  output logic [rdc_pkg::CHAR_BITS-1:0]         out_digit_char,
  output logic                                  out_last_digit,
  output logic                                  out_bad_base,
  input  wire logic                             out_ready
);

  localparam int DEPTH = VW;
  localparam int IDXW  = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_DIV   = 6'b000100,
    S_READ  = 6'b001000,
    S_LOAD  = 6'b010000,
    S_SHOW  = 6'b100000
  } state_t;

  state_t                             state_r, state_nxt;
  logic [VW-1:0]                      quo_r, quo_nxt;
  logic [rdc_pkg::BASE_BITS-1:0]      base_r, base_nxt;
  logic [IDXW-1:0]                    cnt_r, cnt_nxt;
  logic [IDXW-1:0]                    ptr_r, ptr_nxt;
  logic [rdc_pkg::DIGIT_BITS-1:0]     rd_data_r;
  logic                               out_valid_r, out_valid_nxt;
  logic [rdc_pkg::CHAR_BITS-1:0]      out_char_r, out_char_nxt;
  logic                               out_last_r, out_last_nxt;
  logic                               out_bad_r, out_bad_nxt;
  logic                               store_wr;

  logic [rdc_pkg::DIGIT_BITS-1:0]     store_mem [DEPTH];

  logic                               div_start;
  logic                               div_done;
  logic [VW-1:0]                      div_quot;
  logic [rdc_pkg::DIGIT_BITS-1:0]     div_rem;

  // Shared bit-serial divider
  rdc_div #(.VW(VW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (quo_r),
    .divisor   (base_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign div_start = (state_r == S_START);
  assign q_ready   = (state_r == S_IDLE);
  assign store_wr  = (state_r == S_DIV) && div_done;

  // Sequencer: divide until quotient is zero, then play digits back MSD first
  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.bad) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = rdc_pkg::BAD_CHAR;
            out_last_nxt  = 1'b1;
            out_bad_nxt   = 1'b1;
            state_nxt     = S_SHOW;
          end else begin
            quo_nxt   = q_item.value[VW-1:0];
            base_nxt  = q_item.base;
            cnt_nxt   = '0;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          quo_nxt = div_quot;
          if ((div_quot != '0) && (cnt_r != IDXW'(DEPTH - 1))) begin
            cnt_nxt   = cnt_r + IDXW'(1);
            state_nxt = S_START;
          end else begin
            ptr_nxt   = cnt_r;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = rdc_pkg::digit_to_ascii(rd_data_r);
        out_last_nxt  = (ptr_r == '0);
        out_bad_nxt   = 1'b0;
        state_nxt     = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r - IDXW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      quo_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      quo_r       <= quo_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    ptr_r      <= ptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  // Digit store, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store_mem[cnt_r] <= div_rem;
    end
    rd_data_r <= store_mem[ptr_r];
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;
  assign out_bad_base   = out_bad_r;

endmodule

`default_nettype wire

// File: rtl/core/radix_digit_converter.sv
// For an invalid base, the item passes through the queue and the back end then
// raises out_valid from a register. A valid item is divided digit by digit in the
// shared bit-serial divider; each digit is then read from the store and presented.
// The back end takes one item at a time; a two-entry queue takes further items
// meanwhile. Reset (rst_n low, synchronous) empties the queue and drops any
// pending result.
`default_nettype none

module radix_digit_converter #(
  parameter int VALUE_WIDTH = 31
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [rdc_pkg::VALUE_BITS-1:0]   in_value,
  input  wire logic [rdc_pkg::BASE_BITS-1:0]    in_target_base,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [rdc_pkg::CHAR_BITS-1:0]         out_digit_char,
  output logic                                  out_last_digit,
  output logic                                  out_bad_base
);

  // Bits of value that take part in the conversion
  localparam int VW = (VALUE_WIDTH < rdc_pkg::VALUE_BITS) ? VALUE_WIDTH : rdc_pkg::VALUE_BITS;

  logic           push_valid;
  logic           push_ready;
  rdc_pkg::item_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  rdc_pkg::item_t pop_item;

  // Front: accept and classify
  rdc_front #(.VW(VW)) u_front (
    .in_valid       (in_valid),
    .in_value       (in_value),
    .in_target_base (in_target_base),
    .in_ready       (in_ready),
    .push_valid     (push_valid),
    .push_item      (push_item),
    .push_ready     (push_ready)
  );

  // Queue between front and back
  rdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // Back: divide, store digits, emit
  rdc_back #(.VW(VW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (pop_valid),
    .q_item         (pop_item),
    .q_ready        (pop_ready),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .out_bad_base   (out_bad_base),
    .out_ready      (out_ready)
  );

endmodule

`default_nettype wire

// File: rtl/core/rdc_checker.sv
`default_nettype none

module rdc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [30:0] in_value,
  input wire logic [5:0] in_target_base,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] out_digit_char,
  input wire logic       out_last_digit,
  input wire logic       out_bad_base
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled input transfer holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_value) && $stable(in_target_base))
    else $error("stalled input changed");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char) &&
    $stable(out_last_digit) && $stable(out_bad_base))
    else $error("stalled result changed");

  // Bad base result is a single flagged zero
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_base |-> out_last_digit && (out_digit_char == rdc_pkg::BAD_CHAR))
    else $error("bad base result malformed");

  // Digits are '0'-'9' or 'A'-'Z'
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_base |->
    ((out_digit_char >= 7'd48) && (out_digit_char <= 7'd57)) ||
    ((out_digit_char >= 7'd65) && (out_digit_char <= 7'd90)))
    else $error("digit character out of range");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_value       (in_value),
  .in_target_base (in_target_base),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_digit_char (out_digit_char),
  .out_last_digit (out_last_digit),
  .out_bad_base   (out_bad_base)
);

`default_nettype wire
